// ===== hdl/nfcfr_pkg.sv =====
`default_nettype none
package nfcfr_pkg;

  // Receive parser phases; codes above PH_POST behave as hunting.
  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_LEN  = 4'd1,
    PH_LCS  = 4'd2,
    PH_TFI  = 4'd3,
    PH_CMD  = 4'd4,
    PH_DATA = 4'd5,
    PH_DCS  = 4'd6,
    PH_POST = 4'd7
  } phase_t;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_PAYLOAD  = 3'd0;
  localparam kind_t KIND_GOOD     = 3'd1;
  localparam kind_t KIND_ACK      = 3'd2;
  localparam kind_t KIND_LEN_ERR  = 3'd3;
  localparam kind_t KIND_DCS_ERR  = 3'd4;
  localparam kind_t KIND_POST_ERR = 3'd5;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_FF   = 8'hff;
  localparam logic [7:0] MIN_LEN   = 8'd2;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_id;
    logic [7:0] cmd_byte;
    logic       frame_end;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/nfcfr_parser.sv =====
`default_nettype none
module nfcfr_parser (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    step,
  input  wire  [7:0]             rx_byte,
  output logic                   res_valid,
  output nfcfr_pkg::result_t     res
);

  nfcfr_pkg::phase_t phase_r, phase_nxt;
  logic       zero_seen_r, zero_seen_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] held_frame_id_r, held_frame_id_nxt;
  logic [7:0] held_command_r, held_command_nxt;

  logic [7:0] sum_plus_b;
  logic [7:0] len_chk;
  logic [7:0] left_dec;
  logic       is_ack;
  logic       len_bad;

  assign sum_plus_b = running_sum_r + rx_byte;
  assign len_chk    = frame_length_r + rx_byte;
  assign left_dec   = bytes_left_r - 8'd1;
  assign is_ack     = (frame_length_r == nfcfr_pkg::BYTE_ZERO) &&
                      (rx_byte == nfcfr_pkg::BYTE_FF);
  assign len_bad    = (len_chk != nfcfr_pkg::BYTE_ZERO) ||
                      (frame_length_r < nfcfr_pkg::MIN_LEN);

  // next state
  always_comb begin
    phase_nxt         = phase_r;
    zero_seen_nxt     = zero_seen_r;
    frame_length_nxt  = frame_length_r;
    bytes_left_nxt    = bytes_left_r;
    running_sum_nxt   = running_sum_r;
    held_frame_id_nxt = held_frame_id_r;
    held_command_nxt  = held_command_r;
    case (phase_r)
      nfcfr_pkg::PH_LEN: begin
        frame_length_nxt = rx_byte;
        phase_nxt        = nfcfr_pkg::PH_LCS;
      end
      nfcfr_pkg::PH_LCS: begin
        if (is_ack || len_bad) begin
          phase_nxt     = nfcfr_pkg::PH_HUNT;
          zero_seen_nxt = 1'b0;
        end else begin
          bytes_left_nxt    = frame_length_r - nfcfr_pkg::MIN_LEN;
          running_sum_nxt   = nfcfr_pkg::BYTE_ZERO;
          held_frame_id_nxt = nfcfr_pkg::BYTE_ZERO;
          held_command_nxt  = nfcfr_pkg::BYTE_ZERO;
          phase_nxt         = nfcfr_pkg::PH_TFI;
        end
      end
      nfcfr_pkg::PH_TFI: begin
        held_frame_id_nxt = rx_byte;
        running_sum_nxt   = sum_plus_b;
        phase_nxt         = nfcfr_pkg::PH_CMD;
      end
      nfcfr_pkg::PH_CMD: begin
        held_command_nxt = rx_byte;
        running_sum_nxt  = sum_plus_b;
        phase_nxt        = (bytes_left_r != nfcfr_pkg::BYTE_ZERO) ?
                           nfcfr_pkg::PH_DATA : nfcfr_pkg::PH_DCS;
      end
      nfcfr_pkg::PH_DATA: begin
        running_sum_nxt = sum_plus_b;
        bytes_left_nxt  = left_dec;
        if (left_dec == nfcfr_pkg::BYTE_ZERO) begin
          phase_nxt = nfcfr_pkg::PH_DCS;
        end
      end
      nfcfr_pkg::PH_DCS: begin
        running_sum_nxt = sum_plus_b;
        if (sum_plus_b != nfcfr_pkg::BYTE_ZERO) begin
          phase_nxt     = nfcfr_pkg::PH_HUNT;
          zero_seen_nxt = 1'b0;
        end else begin
          phase_nxt = nfcfr_pkg::PH_POST;
        end
      end
      nfcfr_pkg::PH_POST: begin
        phase_nxt     = nfcfr_pkg::PH_HUNT;
        zero_seen_nxt = 1'b0;
      end
      default: begin
        if (zero_seen_r && (rx_byte == nfcfr_pkg::BYTE_FF)) begin
          zero_seen_nxt = 1'b0;
          phase_nxt     = nfcfr_pkg::PH_LEN;
        end else begin
          phase_nxt     = nfcfr_pkg::PH_HUNT;
          zero_seen_nxt = (rx_byte == nfcfr_pkg::BYTE_ZERO);
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_valid        = 1'b0;
    res.kind         = nfcfr_pkg::KIND_PAYLOAD;
    res.payload_byte = nfcfr_pkg::BYTE_ZERO;
    res.frame_id     = held_frame_id_r;
    res.cmd_byte     = held_command_r;
    res.frame_end    = 1'b1;
    case (phase_r)
      nfcfr_pkg::PH_LCS: begin
        res_valid        = is_ack || len_bad;
        res.kind         = is_ack ? nfcfr_pkg::KIND_ACK : nfcfr_pkg::KIND_LEN_ERR;
        res.frame_id     = nfcfr_pkg::BYTE_ZERO;
        res.cmd_byte     = nfcfr_pkg::BYTE_ZERO;
      end
      nfcfr_pkg::PH_DATA: begin
        res_valid        = 1'b1;
        res.kind         = nfcfr_pkg::KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.frame_end    = 1'b0;
      end
      nfcfr_pkg::PH_DCS: begin
        res_valid = (sum_plus_b != nfcfr_pkg::BYTE_ZERO);
        res.kind  = nfcfr_pkg::KIND_DCS_ERR;
      end
      nfcfr_pkg::PH_POST: begin
        res_valid = 1'b1;
        res.kind  = (rx_byte == nfcfr_pkg::BYTE_ZERO) ?
                    nfcfr_pkg::KIND_GOOD : nfcfr_pkg::KIND_POST_ERR;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= nfcfr_pkg::PH_HUNT;
      zero_seen_r     <= 1'b0;
      frame_length_r  <= '0;
      bytes_left_r    <= '0;
      running_sum_r   <= '0;
      held_frame_id_r <= '0;
      held_command_r  <= '0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      zero_seen_r     <= zero_seen_nxt;
      frame_length_r  <= frame_length_nxt;
      bytes_left_r    <= bytes_left_nxt;
      running_sum_r   <= running_sum_nxt;
      held_frame_id_r <= held_frame_id_nxt;
      held_command_r  <= held_command_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/nfc_controller_frame_receiver_unit.sv =====
`default_nettype none
// Channel  | Dir | Ports                                          | Handshake
// ---------+-----+------------------------------------------------+------------------
// input    | in  | in_rx_byte[7:0]                                | in_valid/in_stall
// result   | out | out_kind, out_payload_byte, out_frame_id,      | out_valid/out_stall
//          |     | out_cmd_byte, out_frame_end                    |
//
// One byte is taken per cycle while in_stall is low; its result (if any) is
// registered in the output register, or in the skid register if the output is stalled.
// A skid register behind the output register holds one result while the
// consumer stalls; in_stall is that skid register's full flag, so it is a
// registered signal. Synchronous active-low reset returns the parser to hunting
// for 00 FF and empties both result registers.
module nfc_controller_frame_receiver_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_rx_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_frame_id,
  output logic [7:0]  out_cmd_byte,
  output logic        out_frame_end
);

  logic                in_acc;
  logic                res_valid;
  nfcfr_pkg::result_t  res;

  // Output register and skid register.
  logic                out_valid_r, out_valid_nxt;
  nfcfr_pkg::result_t  out_res_r, out_res_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  nfcfr_pkg::result_t  skid_res_r, skid_res_nxt;

  logic                out_free;

  // A byte transaction is taken whenever the skid register is empty.
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;

  nfcfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register can be loaded when empty or drained this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (out_free) begin
      if (skid_valid_r) begin
        // no new result this cycle: the input is stalled
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_acc && res_valid;
        out_res_nxt   = res;
      end
    end else if (in_acc && res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_payload_byte = out_res_r.payload_byte;
  assign out_frame_id     = out_res_r.frame_id;
  assign out_cmd_byte     = out_res_r.cmd_byte;
  assign out_frame_end    = out_res_r.frame_end;

endmodule
`default_nettype wire

// ===== verif/tb_nfc_controller_frame_receiver_unit.sv =====
`default_nettype none
module tb_nfc_controller_frame_receiver_unit;

  // Random part size, in input bytes (line noise included).
  localparam int RAND_ITEMS   = 1800;
  // Phase of the random run over which idle/stall rates stay fixed.
  localparam int PHASE_ITEMS  = 150;
  // Final stretch of the run with no idling on either side.
  localparam int QUIET_ITEMS  = 250;
  localparam int REPORT_LIMIT = 40;

  // Frame parser predictor plus the queue of results it still expects.
  // note_byte() runs on every accepted input transaction, check_result()
  // on every accepted output transaction.
  class frame_scoreboard;
    nfcfr_pkg::phase_t  phase;
    bit                 zero_seen;
    logic [7:0]         frame_len;
    logic [7:0]         bytes_left;
    logic [7:0]         csum;
    logic [7:0]         tfi;
    logic [7:0]         cmd;
    nfcfr_pkg::result_t expected_q[$];
    int                 fail_count;

    function new();
      phase      = nfcfr_pkg::PH_HUNT;
      zero_seen  = 1'b0;
      frame_len  = 8'h00;
      bytes_left = 8'h00;
      csum       = 8'h00;
      tfi        = 8'h00;
      cmd        = 8'h00;
      fail_count = 0;
    endfunction

    function void push_result(nfcfr_pkg::kind_t k, logic [7:0] pay, bit with_ids);
      nfcfr_pkg::result_t r;
      r.kind         = k;
      r.payload_byte = pay;
      r.frame_id     = with_ids ? tfi : nfcfr_pkg::BYTE_ZERO;
      r.cmd_byte     = with_ids ? cmd : nfcfr_pkg::BYTE_ZERO;
      r.frame_end    = (k != nfcfr_pkg::KIND_PAYLOAD);
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Any frame end forgets a pending 00, so a new 00 FF is required.
    function void back_to_hunt();
      phase     = nfcfr_pkg::PH_HUNT;
      zero_seen = 1'b0;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] len_sum;
      len_sum = frame_len + b;
      case (phase)
        nfcfr_pkg::PH_LEN: begin
          frame_len = b;
          phase     = nfcfr_pkg::PH_LCS;
        end
        nfcfr_pkg::PH_LCS: begin
          if (frame_len == nfcfr_pkg::BYTE_ZERO && b == nfcfr_pkg::BYTE_FF) begin
            back_to_hunt();
            push_result(nfcfr_pkg::KIND_ACK, nfcfr_pkg::BYTE_ZERO, 1'b0);
          end else if (len_sum != nfcfr_pkg::BYTE_ZERO ||
                       frame_len < nfcfr_pkg::MIN_LEN) begin
            back_to_hunt();
            push_result(nfcfr_pkg::KIND_LEN_ERR, nfcfr_pkg::BYTE_ZERO, 1'b0);
          end else begin
            bytes_left = frame_len - nfcfr_pkg::MIN_LEN;
            csum       = 8'h00;
            tfi        = 8'h00;
            cmd        = 8'h00;
            phase      = nfcfr_pkg::PH_TFI;
          end
        end
        nfcfr_pkg::PH_TFI: begin
          tfi   = b;
          csum  = csum + b;
          phase = nfcfr_pkg::PH_CMD;
        end
        nfcfr_pkg::PH_CMD: begin
          cmd   = b;
          csum  = csum + b;
          phase = (bytes_left != 8'h00) ? nfcfr_pkg::PH_DATA : nfcfr_pkg::PH_DCS;
        end
        nfcfr_pkg::PH_DATA: begin
          csum       = csum + b;
          bytes_left = bytes_left - 8'h01;
          if (bytes_left == 8'h00) phase = nfcfr_pkg::PH_DCS;
          push_result(nfcfr_pkg::KIND_PAYLOAD, b, 1'b1);
        end
        nfcfr_pkg::PH_DCS: begin
          csum = csum + b;
          if (csum != 8'h00) begin
            back_to_hunt();
            push_result(nfcfr_pkg::KIND_DCS_ERR, nfcfr_pkg::BYTE_ZERO, 1'b1);
          end else begin
            phase = nfcfr_pkg::PH_POST;
          end
        end
        nfcfr_pkg::PH_POST: begin
          back_to_hunt();
          push_result((b == nfcfr_pkg::BYTE_ZERO) ? nfcfr_pkg::KIND_GOOD :
                      nfcfr_pkg::KIND_POST_ERR, nfcfr_pkg::BYTE_ZERO, 1'b1);
        end
        default: begin
          if (zero_seen && b == nfcfr_pkg::BYTE_FF) begin
            zero_seen = 1'b0;
            phase     = nfcfr_pkg::PH_LEN;
          end else begin
            phase     = nfcfr_pkg::PH_HUNT;
            zero_seen = (b == nfcfr_pkg::BYTE_ZERO);
          end
        end
      endcase
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(nfcfr_pkg::result_t got);
      nfcfr_pkg::result_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, actual kind %h byte %h",
                   $time, got.kind, got.payload_byte);
        return;
      end
      want = expected_q.pop_front();
      field_check("kind", {5'b0, want.kind}, {5'b0, got.kind});
      field_check("payload_byte", want.payload_byte, got.payload_byte);
      field_check("frame_id", want.frame_id, got.frame_id);
      field_check("cmd_byte", want.cmd_byte, got.cmd_byte);
      field_check("frame_end", {7'b0, want.frame_end}, {7'b0, got.frame_end});
    endfunction
  endclass

  // All block inputs start at known values.
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;

  wire        in_stall;
  wire        out_valid;
  wire  [2:0] out_kind;
  wire  [7:0] out_payload_byte;
  wire  [7:0] out_frame_id;
  wire  [7:0] out_cmd_byte;
  wire        out_frame_end;

  frame_scoreboard    sb;
  nfcfr_pkg::result_t mon_res;
  int                 items_sent    = 0;
  int                 in_idle_pct   = 0;  // chance of a gap before a byte
  int                 out_idle_pct  = 0;  // chance of a stall burst per cycle
  int                 next_phase_at = 0;
  int                 drain_cycles  = 0;
  logic [7:0]         directed_bytes[$];

  nfc_controller_frame_receiver_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_id     (out_frame_id),
    .out_cmd_byte     (out_cmd_byte),
    .out_frame_end    (out_frame_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one byte and hold it until the block takes it. All drives are
  // nonblocking at the rising edge; in_stall is sampled as it was before the
  // edge, so an edge with in_valid high and in_stall low is the handshake.
  // A gap deasserts valid for a random burst; without one, valid stays high
  // straight into the next transaction.
  task automatic send_byte(input logic [7:0] b, input bit counted);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_byte(b);
    if (counted) items_sent++;
  endtask

  // One random frame attempt. Most are well-formed with random content so
  // the data and checksum phases get exercised; the rest are ACKs, bad
  // headers, data checksum and postamble errors, and frames cut short
  // (whose leftovers then get parsed by whatever phase the block is in).
  task automatic send_random_frame();
    int         sel;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    int         cut;
    sel = $urandom_range(0, 99);
    // A little line noise ahead of the start code.
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(nfcfr_pkg::BYTE_ZERO, 1'b1);
    send_byte(nfcfr_pkg::BYTE_FF, 1'b1);
    if (sel < 8) begin
      send_byte(nfcfr_pkg::BYTE_ZERO, 1'b1);
      send_byte(nfcfr_pkg::BYTE_FF, 1'b1);
    end else if (sel < 14) begin
      // Bad header: either LCS off by a nonzero amount, or LEN 0/1 with a
      // matching LCS.
      if ($urandom_range(0, 1) == 0) begin
        len = 8'($urandom_range(0, 255));
        send_byte(len, 1'b1);
        send_byte(8'h00 - len + 8'($urandom_range(1, 255)), 1'b1);
      end else begin
        len = 8'($urandom_range(0, 1));
        send_byte(len, 1'b1);
        send_byte(8'h00 - len, 1'b1);
      end
    end else begin
      // LEN mostly small, now and then anywhere up to the maximum.
      len = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(2, 255)) :
            8'($urandom_range(2, 12));
      cut = (sel < 18) ? $urandom_range(0, 3) : 1000;
      send_byte(len, 1'b1);
      send_byte(8'h00 - len, 1'b1);
      if (cut == 0) return;
      b = ($urandom_range(0, 1) == 0) ? 8'hd5 : 8'($urandom_range(0, 255));
      sum = b;
      send_byte(b, 1'b1);
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      send_byte(b, 1'b1);
      for (int i = 2; i < len; i++) begin
        if (i - 1 >= cut) return;
        b = 8'($urandom_range(0, 255));
        sum = sum + b;
        send_byte(b, 1'b1);
      end
      if (cut < 1000) return;
      if (sel < 30) begin
        send_byte(8'h00 - sum + 8'($urandom_range(1, 255)), 1'b1);
      end else begin
        send_byte(8'h00 - sum, 1'b1);
        send_byte((sel < 37) ? 8'($urandom_range(1, 255)) : nfcfr_pkg::BYTE_ZERO,
                  1'b1);
      end
    end
  endtask

  // Result side: random stall bursts at the rate of the current phase.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result monitor: a transaction is an edge with out_valid high and
  // out_stall low, both as they stood before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      mon_res.kind         = out_kind;
      mon_res.payload_byte = out_payload_byte;
      mon_res.frame_id     = out_frame_id;
      mon_res.cmd_byte     = out_cmd_byte;
      mon_res.frame_end    = out_frame_end;
      sb.check_result(mon_res);
    end
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames:
    //   noise then 00 00 FF start, ACK
    //   length checksum mismatch
    //   short length (LEN 01, LCS FF)
    //   LEN 3, TFI FF, cmd 00, payload 80, good DCS and postamble
    //   lone FF after a frame end (no start), then a data checksum error
    directed_bytes = '{8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff,
                       8'h00, 8'hff, 8'h05, 8'h00,
                       8'h00, 8'hff, 8'h01, 8'hff,
                       8'h00, 8'hff, 8'h03, 8'hfd, 8'hff, 8'h00, 8'h80, 8'h81, 8'h00,
                       8'hff, 8'h00, 8'hff, 8'h02, 8'hfe, 8'h00, 8'h00, 8'h01};
    foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b1);

    // Random frames; idle rates change per phase, none at the end.
    items_sent    = 0;
    next_phase_at = 0;
    while (items_sent < RAND_ITEMS) begin
      if (items_sent >= next_phase_at) begin
        next_phase_at += PHASE_ITEMS;
        if (items_sent >= RAND_ITEMS - QUIET_ITEMS) begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end else begin
          case ($urandom_range(0, 3))
            0:       in_idle_pct = 0;
            1:       in_idle_pct = 5;
            2:       in_idle_pct = 20;
            default: in_idle_pct = 40;
          endcase
          case ($urandom_range(0, 3))
            0:       out_idle_pct = 0;
            1:       out_idle_pct = 5;
            2:       out_idle_pct = 20;
            default: out_idle_pct = 40;
          endcase
        end
      end
      send_random_frame();
    end
    in_idle_pct  = 0;
    out_idle_pct = 0;
    in_valid    <= 1'b0;

    // Drain, then wait a little longer for anything extra the block might emit.
    while (sb.expected_q.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.fail_count++;
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, sb.expected_q.size());
    end

    if (sb.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/nfcfr_pkg.sv
hdl/nfcfr_parser.sv
hdl/nfc_controller_frame_receiver_unit.sv
verif/tb_nfc_controller_frame_receiver_unit.sv
